FILE: hw/rtl/twhsm_pkg.sv
`default_nettype none

package twhsm_pkg;

   // Command that reads the one-byte status register; all others measure
   localparam logic [4:0] CMD_STATUS = 5'd7;
   // Reflected CRC-8 polynomial
   localparam logic [7:0] CRC_POLY = 8'h8C;

   // One result transaction
   typedef struct packed {
      logic        sck_level;
      logic        data_drive_low;
      logic        busy_res;
      logic        done_res;
      logic        ack_error;
      logic [15:0] reading;
      logic [7:0]  crc_from_sensor;
      logic [7:0]  crc_calculated;
   } result_type;

   function automatic logic [7:0] rev8(input logic [7:0] b);
      logic [7:0] r;
      for (int k = 0; k < 8; k++) begin
         r[k] = b[7 - k];
      end
      return r;
   endfunction

   // Bit-reversed byte in, shifted out LSB first
   function automatic logic [7:0] crc_add(input logic [7:0] crc, input logic [7:0] b);
      logic [7:0] c;
      c = crc ^ rev8(b);
      for (int k = 0; k < 8; k++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/twhsm_seq.sv
`default_nettype none

module twhsm_seq (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   step,
   input  wire logic                   req_type,
   input  wire logic [4:0]             command,
   input  wire logic                   data_pin,
   output twhsm_pkg::result_type       result
);

   typedef enum logic [4:0] {
      PH_IDLE   = 5'd0,
      PH_START  = 5'd1,
      PH_TX_HI  = 5'd2,
      PH_TX_LO  = 5'd3,
      PH_AK_HI  = 5'd4,
      PH_AK_LO  = 5'd5,
      PH_W_HIGH = 5'd6,
      PH_W_LOW  = 5'd7,
      PH_R1_HI  = 5'd8,
      PH_R1_LO  = 5'd9,
      PH_R2_HI  = 5'd10,
      PH_R2_LO  = 5'd11,
      PH_RC_HI  = 5'd12,
      PH_RC_LO  = 5'd13,
      PH_A1_HI  = 5'd14,
      PH_A1_LO  = 5'd15,
      PH_A2_HI  = 5'd16,
      PH_A2_LO  = 5'd17,
      PH_NA_HI  = 5'd18,
      PH_NA_LO  = 5'd19
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [2:0]  bit_count_ff, bit_count_in;
   logic [7:0]  shift_byte_ff, shift_byte_in;
   logic [4:0]  command_ff, command_in;
   logic [15:0] value_ff, value_in;
   logic [7:0]  crc_ff, crc_in;
   logic [7:0]  crc_rx_ff, crc_rx_in;
   logic        sck_ff, sck_in;
   logic        data_low_ff, data_low_in;
   logic        nack_ff, nack_in;
   logic        done_in;

   // Next state for one transaction on the request channel
   always_comb begin
      phase_in      = phase_ff;
      bit_count_in  = bit_count_ff;
      shift_byte_in = shift_byte_ff;
      command_in    = command_ff;
      value_in      = value_ff;
      crc_in        = crc_ff;
      crc_rx_in     = crc_rx_ff;
      sck_in        = sck_ff;
      data_low_in   = data_low_ff;
      nack_in       = nack_ff;
      done_in       = 1'b0;

      if (req_type) begin
         // start only from idle; ignored otherwise
         if (phase_ff == PH_IDLE) begin
            command_in    = command;
            shift_byte_in = {3'b000, command};
            value_in      = '0;
            crc_in        = '0;
            crc_rx_in     = '0;
            nack_in       = 1'b0;
            sck_in        = 1'b0;
            data_low_in   = 1'b0;
            bit_count_in  = '0;
            phase_in      = PH_START;
         end
      end else begin
         case (phase_ff)
            PH_START: begin
               case (bit_count_ff)
                  3'd0: sck_in = 1'b1;
                  3'd1: data_low_in = 1'b1;
                  3'd2: sck_in = 1'b0;
                  3'd3: sck_in = 1'b1;
                  3'd4: data_low_in = 1'b0;
                  3'd5: sck_in = 1'b0;
                  default: ;
               endcase
               if (bit_count_ff >= 3'd6) begin
                  bit_count_in = 3'd7;
                  data_low_in  = ~shift_byte_ff[7];
                  phase_in     = PH_TX_HI;
               end else begin
                  bit_count_in = bit_count_ff + 3'd1;
               end
            end
            PH_TX_HI: begin
               sck_in   = 1'b1;
               phase_in = PH_TX_LO;
            end
            PH_TX_LO: begin
               sck_in = 1'b0;
               if (bit_count_ff != 3'd0) begin
                  bit_count_in = bit_count_ff - 3'd1;
                  data_low_in  = ~shift_byte_ff[bit_count_ff - 3'd1];
                  phase_in     = PH_TX_HI;
               end else begin
                  data_low_in = 1'b0;
                  phase_in    = PH_AK_HI;
               end
            end
            PH_AK_HI: begin
               sck_in   = 1'b1;
               crc_in   = twhsm_pkg::crc_add(8'h00, {3'b000, command_ff});
               nack_in  = data_pin;
               phase_in = PH_AK_LO;
            end
            PH_AK_LO: begin
               sck_in        = 1'b0;
               bit_count_in  = 3'd7;
               shift_byte_in = '0;
               if (nack_ff) begin
                  done_in  = 1'b1;
                  phase_in = PH_IDLE;
               end else if (command_ff == twhsm_pkg::CMD_STATUS) begin
                  phase_in = PH_R2_HI;
               end else begin
                  phase_in = PH_W_HIGH;
               end
            end
            // conversion wait: DATA rises, then falls when the value is ready
            PH_W_HIGH: begin
               if (data_pin) begin
                  phase_in = PH_W_LOW;
               end
            end
            PH_W_LOW: begin
               if (!data_pin) begin
                  bit_count_in  = 3'd7;
                  shift_byte_in = '0;
                  phase_in      = PH_R1_HI;
               end
            end
            PH_R1_HI, PH_R2_HI, PH_RC_HI: begin
               sck_in        = 1'b1;
               shift_byte_in = {shift_byte_ff[6:0], data_pin};
               phase_in      = (phase_ff == PH_R1_HI) ? PH_R1_LO :
                               (phase_ff == PH_R2_HI) ? PH_R2_LO : PH_RC_LO;
            end
            PH_R1_LO, PH_R2_LO, PH_RC_LO: begin
               sck_in = 1'b0;
               if (bit_count_ff != 3'd0) begin
                  bit_count_in = bit_count_ff - 3'd1;
                  phase_in     = (phase_ff == PH_R1_LO) ? PH_R1_HI :
                                 (phase_ff == PH_R2_LO) ? PH_R2_HI : PH_RC_HI;
               end else if (phase_ff == PH_R1_LO) begin
                  value_in    = {shift_byte_ff, 8'h00};
                  crc_in      = twhsm_pkg::crc_add(crc_ff, shift_byte_ff);
                  data_low_in = 1'b1;
                  phase_in    = PH_A1_HI;
               end else if (phase_ff == PH_R2_LO) begin
                  value_in    = value_ff | {8'h00, shift_byte_ff};
                  crc_in      = twhsm_pkg::crc_add(crc_ff, shift_byte_ff);
                  data_low_in = 1'b1;
                  phase_in    = PH_A2_HI;
               end else begin
                  crc_rx_in   = shift_byte_ff;
                  data_low_in = 1'b0;
                  phase_in    = PH_NA_HI;
               end
            end
            PH_A1_HI, PH_A2_HI, PH_NA_HI: begin
               sck_in   = 1'b1;
               phase_in = (phase_ff == PH_A1_HI) ? PH_A1_LO :
                          (phase_ff == PH_A2_HI) ? PH_A2_LO : PH_NA_LO;
            end
            PH_A1_LO, PH_A2_LO: begin
               sck_in        = 1'b0;
               data_low_in   = 1'b0;
               bit_count_in  = 3'd7;
               shift_byte_in = '0;
               phase_in      = (phase_ff == PH_A1_LO) ? PH_R2_HI : PH_RC_HI;
            end
            PH_NA_LO: begin
               sck_in      = 1'b0;
               data_low_in = 1'b0;
               done_in     = 1'b1;
               phase_in    = PH_IDLE;
            end
            default: begin
               phase_in = PH_IDLE;
            end
         endcase
      end
   end

   // Sequencer state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         bit_count_ff  <= '0;
         shift_byte_ff <= '0;
         command_ff    <= '0;
         value_ff      <= '0;
         crc_ff        <= '0;
         crc_rx_ff     <= '0;
         sck_ff        <= 1'b0;
         data_low_ff   <= 1'b0;
         nack_ff       <= 1'b0;
      end else if (step) begin
         phase_ff      <= phase_in;
         bit_count_ff  <= bit_count_in;
         shift_byte_ff <= shift_byte_in;
         command_ff    <= command_in;
         value_ff      <= value_in;
         crc_ff        <= crc_in;
         crc_rx_ff     <= crc_rx_in;
         sck_ff        <= sck_in;
         data_low_ff   <= data_low_in;
         nack_ff       <= nack_in;
      end
   end

   // Result of this transaction: the state it leaves behind
   always_comb begin
      result.sck_level       = sck_in;
      result.data_drive_low  = data_low_in;
      result.busy_res        = (phase_in != PH_IDLE);
      result.done_res        = done_in;
      result.ack_error       = nack_in;
      result.reading         = value_in;
      result.crc_from_sensor = crc_rx_in;
      result.crc_calculated  = crc_in;
   end

endmodule

`default_nettype wire

FILE: hw/rtl/two_wire_humidity_sensor_master_top.sv
`default_nettype none

// Two-wire sensor bus master. Each request transaction is a start (req_type = 1,
// command latched, taken only when idle) or one bus half-period tick carrying the
// sampled DATA level; each gives exactly one response with the SCK and DATA drive
// levels, busy/done flags, the reading and both CRC bytes. One request is taken
// per clock cycle: the sequencer steps in the cycle of acceptance and its result
// lands in a two-entry output stage (output register plus skid register), so
// req_ready only drops while both entries hold undelivered responses.
module two_wire_humidity_sensor_master_top (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output      logic        req_ready,
   input  wire logic        req_type,
   input  wire logic [4:0]  req_command,
   input  wire logic        req_data_pin,
   output      logic        rsp_valid,
   input  wire logic        rsp_ready,
   output      logic        rsp_sck_level,
   output      logic        rsp_data_drive_low,
   output      logic        rsp_busy_res,
   output      logic        rsp_done_res,
   output      logic        rsp_ack_error,
   output      logic [15:0] rsp_reading,
   output      logic [7:0]  rsp_crc_from_sensor,
   output      logic [7:0]  rsp_crc_calculated
);

   twhsm_pkg::result_type step_result;
   twhsm_pkg::result_type out_ff;
   twhsm_pkg::result_type skid_ff;
   logic                  out_valid_ff;
   logic                  skid_valid_ff;
   logic                  accept;
   logic                  pop;

   assign req_ready = ~skid_valid_ff;
   assign accept    = req_valid & req_ready;
   assign pop       = out_valid_ff & rsp_ready;

   twhsm_seq u_seq (
      .clock    (clock),
      .reset    (reset),
      .step     (accept),
      .req_type (req_type),
      .command  (req_command),
      .data_pin (req_data_pin),
      .result   (step_result)
   );

   // Output register with skid entry
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (!out_valid_ff || pop) begin
         if (skid_valid_ff) begin
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            out_valid_ff <= accept;
         end
      end else if (accept) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!out_valid_ff || pop) begin
         if (skid_valid_ff) begin
            out_ff <= skid_ff;
         end else if (accept) begin
            out_ff <= step_result;
         end
      end else if (accept) begin
         skid_ff <= step_result;
      end
   end

   assign rsp_valid           = out_valid_ff;
   assign rsp_sck_level       = out_ff.sck_level;
   assign rsp_data_drive_low  = out_ff.data_drive_low;
   assign rsp_busy_res        = out_ff.busy_res;
   assign rsp_done_res        = out_ff.done_res;
   assign rsp_ack_error       = out_ff.ack_error;
   assign rsp_reading         = out_ff.reading;
   assign rsp_crc_from_sensor = out_ff.crc_from_sensor;
   assign rsp_crc_calculated  = out_ff.crc_calculated;

endmodule

`default_nettype wire

FILE: verif/tb.sv
`timescale 1ns / 1ps

module tb;

   // Sequencer steps of the bus master, in the block's own encoding order
   typedef enum logic [4:0] {
      S_IDLE, S_START, S_CMD_HI, S_CMD_LO, S_ACK_HI, S_ACK_LO, S_WAIT_RISE, S_WAIT_FALL,
      S_MSB_HI, S_MSB_LO, S_LSB_HI, S_LSB_LO, S_CRC_HI, S_CRC_LO, S_ACK1_HI, S_ACK1_LO,
      S_ACK2_HI, S_ACK2_LO, S_NOACK_HI, S_NOACK_LO
   } bus_phase_type;

   localparam logic REQ_TICK  = 1'b0;
   localparam logic REQ_START = 1'b1;
   localparam int   RANDOM_ITEMS = 1000;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic        req_type;
   logic [4:0]  req_command;
   logic        req_data_pin;
   logic        rsp_valid;
   logic        rsp_ready;
   logic        rsp_sck_level;
   logic        rsp_data_drive_low;
   logic        rsp_busy_res;
   logic        rsp_done_res;
   logic        rsp_ack_error;
   logic [15:0] rsp_reading;
   logic [7:0]  rsp_crc_from_sensor;
   logic [7:0]  rsp_crc_calculated;

   // Predicted bus master state
   bus_phase_type m_phase;
   logic [2:0]  m_bits;
   logic [7:0]  m_shift;
   logic [4:0]  m_cmd;
   logic [15:0] m_value;
   logic [7:0]  m_crc;
   logic [7:0]  m_crc_rx;
   logic        m_sck;
   logic        m_dlow;
   logic        m_nack;

   twhsm_pkg::result_type expected_bus_states[$];
   int          err_count;
   int          items_sent;
   int          burst_left;

   // Receiver control
   bit          rx_hold_req;
   int          rx_hold_left;
   int          rx_mode;
   int          rx_mode_left;
   int          rx_phase_cnt;

   two_wire_humidity_sensor_master_top u_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_type            (req_type),
      .req_command         (req_command),
      .req_data_pin        (req_data_pin),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_sck_level       (rsp_sck_level),
      .rsp_data_drive_low  (rsp_data_drive_low),
      .rsp_busy_res        (rsp_busy_res),
      .rsp_done_res        (rsp_done_res),
      .rsp_ack_error       (rsp_ack_error),
      .rsp_reading         (rsp_reading),
      .rsp_crc_from_sensor (rsp_crc_from_sensor),
      .rsp_crc_calculated  (rsp_crc_calculated)
   );

   always #1 clock = ~clock;

   // CRC-8 update: byte bit-reversed, then shifted LSB first through 0x8C
   function automatic logic [7:0] crc8_reflected(input logic [7:0] acc, input logic [7:0] b);
      logic [7:0] flipped;
      logic [7:0] c;
      for (int k = 0; k < 8; k++) begin
         flipped[k] = b[7 - k];
      end
      c = acc ^ flipped;
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ 8'h8C) : (c >> 1);
      end
      return c;
   endfunction

   function automatic void reset_bus_model();
      m_phase  = S_IDLE;
      m_bits   = '0;
      m_shift  = '0;
      m_cmd    = '0;
      m_value  = '0;
      m_crc    = '0;
      m_crc_rx = '0;
      m_sck    = 1'b0;
      m_dlow   = 1'b0;
      m_nack   = 1'b0;
   endfunction

   // Advance the predicted master by one request and return the expected response
   function automatic twhsm_pkg::result_type predict_bus_step(input logic rt,
                                                              input logic [4:0] cmd,
                                                              input logic pin);
      twhsm_pkg::result_type r;
      logic       fin;
      fin = 1'b0;
      if (rt == REQ_START) begin
         // a start while busy is dropped
         if (m_phase == S_IDLE) begin
            m_cmd    = cmd;
            m_shift  = {3'b000, cmd};
            m_value  = '0;
            m_crc    = '0;
            m_crc_rx = '0;
            m_nack   = 1'b0;
            m_sck    = 1'b0;
            m_dlow   = 1'b0;
            m_bits   = '0;
            m_phase  = S_START;
         end
      end else begin
         case (m_phase)
            S_START: begin
               case (m_bits)
                  3'd0: m_sck = 1'b1;
                  3'd1: m_dlow = 1'b1;
                  3'd2: m_sck = 1'b0;
                  3'd3: m_sck = 1'b1;
                  3'd4: m_dlow = 1'b0;
                  3'd5: m_sck = 1'b0;
                  default: ;
               endcase
               if (m_bits >= 3'd6) begin
                  m_bits  = 3'd7;
                  m_dlow  = ~m_shift[7];
                  m_phase = S_CMD_HI;
               end else begin
                  m_bits = m_bits + 3'd1;
               end
            end
            S_CMD_HI: begin
               m_sck   = 1'b1;
               m_phase = S_CMD_LO;
            end
            S_CMD_LO: begin
               m_sck = 1'b0;
               if (m_bits != 3'd0) begin
                  m_bits  = m_bits - 3'd1;
                  m_dlow  = ~m_shift[m_bits];
                  m_phase = S_CMD_HI;
               end else begin
                  m_dlow  = 1'b0;
                  m_phase = S_ACK_HI;
               end
            end
            S_ACK_HI: begin
               m_sck   = 1'b1;
               m_crc   = crc8_reflected(8'h00, {3'b000, m_cmd});
               m_nack  = pin;
               m_phase = S_ACK_LO;
            end
            S_ACK_LO: begin
               m_sck   = 1'b0;
               m_bits  = 3'd7;
               m_shift = '0;
               if (m_nack) begin
                  fin     = 1'b1;
                  m_phase = S_IDLE;
               end else if (m_cmd == twhsm_pkg::CMD_STATUS) begin
                  m_phase = S_LSB_HI;
               end else begin
                  m_phase = S_WAIT_RISE;
               end
            end
            S_WAIT_RISE: begin
               if (pin) begin
                  m_phase = S_WAIT_FALL;
               end
            end
            S_WAIT_FALL: begin
               if (!pin) begin
                  m_bits  = 3'd7;
                  m_shift = '0;
                  m_phase = S_MSB_HI;
               end
            end
            S_MSB_HI, S_LSB_HI, S_CRC_HI: begin
               m_sck   = 1'b1;
               m_shift = {m_shift[6:0], pin};
               m_phase = (m_phase == S_MSB_HI) ? S_MSB_LO :
                         (m_phase == S_LSB_HI) ? S_LSB_LO : S_CRC_LO;
            end
            S_MSB_LO, S_LSB_LO, S_CRC_LO: begin
               m_sck = 1'b0;
               if (m_bits != 3'd0) begin
                  m_bits  = m_bits - 3'd1;
                  m_phase = (m_phase == S_MSB_LO) ? S_MSB_HI :
                            (m_phase == S_LSB_LO) ? S_LSB_HI : S_CRC_HI;
               end else if (m_phase == S_MSB_LO) begin
                  m_value = {m_shift, 8'h00};
                  m_crc   = crc8_reflected(m_crc, m_shift);
                  m_dlow  = 1'b1;
                  m_phase = S_ACK1_HI;
               end else if (m_phase == S_LSB_LO) begin
                  m_value = m_value | {8'h00, m_shift};
                  m_crc   = crc8_reflected(m_crc, m_shift);
                  m_dlow  = 1'b1;
                  m_phase = S_ACK2_HI;
               end else begin
                  m_crc_rx = m_shift;
                  m_dlow   = 1'b0;
                  m_phase  = S_NOACK_HI;
               end
            end
            S_ACK1_HI, S_ACK2_HI, S_NOACK_HI: begin
               m_sck   = 1'b1;
               m_phase = (m_phase == S_ACK1_HI) ? S_ACK1_LO :
                         (m_phase == S_ACK2_HI) ? S_ACK2_LO : S_NOACK_LO;
            end
            S_ACK1_LO, S_ACK2_LO: begin
               m_sck   = 1'b0;
               m_dlow  = 1'b0;
               m_bits  = 3'd7;
               m_shift = '0;
               m_phase = (m_phase == S_ACK1_LO) ? S_LSB_HI : S_CRC_HI;
            end
            S_NOACK_LO: begin
               m_sck   = 1'b0;
               m_dlow  = 1'b0;
               fin     = 1'b1;
               m_phase = S_IDLE;
            end
            default: m_phase = S_IDLE;
         endcase
      end
      r.sck_level       = m_sck;
      r.data_drive_low  = m_dlow;
      r.busy_res        = (m_phase != S_IDLE);
      r.done_res        = fin;
      r.ack_error       = m_nack;
      r.reading         = m_value;
      r.crc_from_sensor = m_crc_rx;
      r.crc_calculated  = m_crc;
      return r;
   endfunction

   // Offer one request in bursts with random gaps; predict on acceptance
   task automatic send_req(input logic rt, input logic [4:0] cmd, input logic pin);
      if (burst_left == 0) begin
         if ($urandom_range(9) == 0) begin
            burst_left = 300;
         end else begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clock);
            burst_left = $urandom_range(1, 30);
         end
      end
      burst_left--;
      req_valid    <= 1'b1;
      req_type     <= rt;
      req_command  <= cmd;
      req_data_pin <= pin;
      do @(posedge clock); while (!req_ready);
      expected_bus_states.push_back(predict_bus_step(rt, cmd, pin));
      items_sent++;
      @(negedge clock);
   endtask

   // Hold off new requests until every response is back
   task automatic drain_results();
      req_valid <= 1'b0;
      while (expected_bus_states.size() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   // Play one transaction as a sensor would answer it; noise_pct injects starts while busy
   task automatic run_transfer(input logic [4:0] cmd, input bit nack, input int rise_wait,
                               input int fall_wait, input logic [7:0] msb,
                               input logic [7:0] lsb, input bit good_crc, input int noise_pct);
      logic       pin;
      int         rise_left;
      int         fall_left;
      logic [7:0] crc_sent;
      rise_left = rise_wait;
      fall_left = fall_wait;
      crc_sent  = 8'($urandom);
      send_req(REQ_START, cmd, 1'($urandom));
      while (m_phase != S_IDLE) begin
         if ($urandom_range(99) < noise_pct) begin
            send_req(REQ_START, 5'($urandom), 1'($urandom));
         end else begin
            case (m_phase)
               S_ACK_HI: pin = nack;
               S_WAIT_RISE: begin
                  pin = (rise_left == 0);
                  if (rise_left > 0) rise_left--;
               end
               S_WAIT_FALL: begin
                  pin = (fall_left != 0);
                  if (fall_left > 0) fall_left--;
               end
               S_MSB_HI: pin = msb[m_bits];
               S_LSB_HI: pin = lsb[m_bits];
               S_CRC_HI: pin = good_crc ? m_crc[m_bits] : crc_sent[m_bits];
               default:  pin = 1'($urandom);
            endcase
            send_req(REQ_TICK, 5'($urandom), pin);
         end
      end
   endtask

   // Ticks while idle do nothing
   task automatic test_idle_ticks();
      send_req(REQ_TICK, 5'd0, 1'b0);
      send_req(REQ_TICK, 5'd31, 1'b1);
      send_req(REQ_TICK, 5'd21, 1'b0);
   endtask

   task automatic test_status_read();
      run_transfer(twhsm_pkg::CMD_STATUS, 1'b0, 0, 0, 8'h00, 8'hFF, 1'b1, 0);
      run_transfer(twhsm_pkg::CMD_STATUS, 1'b0, 0, 0, 8'h00, 8'h5A, 1'b0, 0);
   endtask

   // Commands at both ends of the range, with extreme data and wait lengths
   task automatic test_measure_extremes();
      run_transfer(5'd0, 1'b0, 0, 0, 8'hFF, 8'h00, 1'b1, 0);
      run_transfer(5'd31, 1'b0, 40, 40, 8'h00, 8'hFF, 1'b0, 0);
      run_transfer(5'd3, 1'b0, 1, 0, 8'hA5, 8'h3C, 1'b1, 0);
   endtask

   task automatic test_nack();
      run_transfer(5'd31, 1'b1, 0, 0, 8'h00, 8'h00, 1'b0, 0);
      run_transfer(twhsm_pkg::CMD_STATUS, 1'b1, 0, 0, 8'h00, 8'h00, 1'b0, 0);
   endtask

   task automatic test_start_while_busy();
      run_transfer(5'd5, 1'b0, 2, 2, 8'h12, 8'h34, 1'b1, 30);
   endtask

   // Receiver stalls for a long stretch while requests keep coming
   task automatic test_response_backpressure();
      rx_hold_req = 1'b1;
      run_transfer(5'd16, 1'b0, 3, 1, 8'h81, 8'h7E, 1'b1, 0);
      drain_results();
      run_transfer(twhsm_pkg::CMD_STATUS, 1'b0, 0, 0, 8'h00, 8'hC3, 1'b1, 0);
   endtask

   task automatic test_random_traffic();
      int          start_cnt;
      int          roll;
      logic [4:0]  cmd;
      int          rise_wait;
      int          fall_wait;
      start_cnt = items_sent;
      while (items_sent - start_cnt < RANDOM_ITEMS) begin
         roll = $urandom_range(99);
         if (roll < 8) begin
            // loose requests: idle ticks, random starts and random pins
            repeat ($urandom_range(1, 4)) begin
               send_req(1'($urandom), 5'($urandom), 1'($urandom));
            end
         end else if (roll < 11) begin
            drain_results();
         end else if (roll < 13) begin
            rx_hold_req = 1'b1;
         end else begin
            cmd       = ($urandom_range(99) < 30) ? twhsm_pkg::CMD_STATUS : 5'($urandom);
            rise_wait = ($urandom_range(9) == 0) ? $urandom_range(0, 20) : $urandom_range(0, 3);
            fall_wait = ($urandom_range(9) == 0) ? $urandom_range(0, 20) : $urandom_range(0, 3);
            run_transfer(cmd, $urandom_range(99) < 12, rise_wait, fall_wait,
                         8'($urandom), 8'($urandom), 1'($urandom),
                         ($urandom_range(9) == 0) ? 5 : 0);
         end
      end
   endtask

   function automatic void check_field(input string name, input logic [15:0] exp_v,
                                       input logic [15:0] got_v);
      if (got_v !== exp_v) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, got_v);
         err_count++;
      end
   endfunction

   // Response checker
   always @(posedge clock) begin
      twhsm_pkg::result_type exp_r;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_bus_states.size() == 0) begin
            $error("response transaction with no request pending");
            err_count++;
         end else begin
            exp_r = expected_bus_states.pop_front();
            check_field("sck_level", 16'(exp_r.sck_level), 16'(rsp_sck_level));
            check_field("data_drive_low", 16'(exp_r.data_drive_low), 16'(rsp_data_drive_low));
            check_field("busy_res", 16'(exp_r.busy_res), 16'(rsp_busy_res));
            check_field("done_res", 16'(exp_r.done_res), 16'(rsp_done_res));
            check_field("ack_error", 16'(exp_r.ack_error), 16'(rsp_ack_error));
            check_field("reading", exp_r.reading, rsp_reading);
            check_field("crc_from_sensor", 16'(exp_r.crc_from_sensor), 16'(rsp_crc_from_sensor));
            check_field("crc_calculated", 16'(exp_r.crc_calculated), 16'(rsp_crc_calculated));
         end
      end
   end

   // Response ready: rotating stall patterns, plus a long hold on request
   always @(negedge clock) begin
      if (rx_hold_req) begin
         rx_hold_req  = 1'b0;
         rx_hold_left = 100;
      end
      if (rx_hold_left > 0) begin
         rx_hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         if (rx_mode_left == 0) begin
            rx_mode      = $urandom_range(3);
            rx_mode_left = $urandom_range(20, 200);
         end
         rx_mode_left--;
         rx_phase_cnt++;
         case (rx_mode)
            0:       rsp_ready <= 1'b1;
            1:       rsp_ready <= 1'($urandom);
            2:       rsp_ready <= (rx_phase_cnt % 5) < 3;
            default: rsp_ready <= ($urandom_range(9) != 0);
         endcase
      end
   end

   // Run limit
   initial begin
      #1000000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      clock        = 1'b0;
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_type     = REQ_TICK;
      req_command  = '0;
      req_data_pin = 1'b0;
      rsp_ready    = 1'b0;
      err_count    = 0;
      items_sent   = 0;
      burst_left   = 0;
      rx_hold_req  = 1'b0;
      rx_hold_left = 0;
      rx_mode      = 0;
      rx_mode_left = 0;
      rx_phase_cnt = 0;
      reset_bus_model();
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_idle_ticks();
      test_status_read();
      test_measure_extremes();
      test_nack();
      test_start_while_busy();
      test_response_backpressure();
      test_random_traffic();

      // wind down: all responses back, then let the output stage settle
      req_valid <= 1'b0;
      while (expected_bus_states.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (err_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

FILE: files.f
hw/rtl/twhsm_pkg.sv
hw/rtl/twhsm_seq.sv
hw/rtl/two_wire_humidity_sensor_master_top.sv
verif/tb.sv
